[hw/rtl/fbla_pkg.sv]
// Shared types and constants for the fixed block free list allocator.
// Holds the beat structs, the status and operation codes, and the controller types.
`timescale 1ns / 1ps

package fbla_pkg;

   localparam logic       OP_ALLOC = 1'b0;
   localparam logic       OP_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

   localparam logic [8:0] BLOCK_COUNT_RESET = 9'd256;

   typedef struct packed {
      logic       cmd;
      logic [7:0] free_index;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] block_index;
      logic [8:0] free_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic rsp_ready;
   } ctrl_sts_type;

endpackage

[hw/rtl/fbla_ctrl.sv]
// Controller state machine of the allocator: list rebuild, beat intake and commit.
// Depends on fbla_pkg for the state and command types.
`timescale 1ns / 1ps

module fbla_ctrl import fbla_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         csr_wr_en,
   input  ctrl_sts_type sts,
   output logic         req_stall,
   output ctrl_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_stall = 1'b1;
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.rsp_ready) begin
               cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      if (csr_wr_en) begin
         state_in = ST_CLEAR;
      end
   end

endmodule

[hw/rtl/fbla_datapath.sv]
// Datapath of the allocator: link memory, head, free counter and result register.
// Depends on fbla_pkg for beat structs, codes and controller types.
`timescale 1ns / 1ps

module fbla_datapath import fbla_pkg::*; #(
   parameter int MAX_BLOCKS = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   output ctrl_sts_type sts,
   input  req_type      req_data,
   input  logic         csr_wr_en,
   input  logic [8:0]   csr_wr_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   localparam int LINK_W   = $clog2(MAX_BLOCKS + 1);
   localparam int ADDR_W   = $clog2(MAX_BLOCKS);
   localparam int CNT_W    = ADDR_W + 1;
   localparam int CMP_W    = (LINK_W > 9) ? LINK_W : 9;
   localparam int RST_SIZE = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;

   logic [LINK_W-1:0] link_mem [MAX_BLOCKS];

   logic [8:0]        block_count_ff;
   logic [LINK_W-1:0] head_ff;
   logic [8:0]        free_ff;
   logic              op_ff;
   logic [7:0]        idx_ff;
   logic [LINK_W-1:0] rd_data_ff;
   logic [CNT_W-1:0]  clr_cnt_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic              rsp_valid_in;
   rsp_type           rsp_in;
   logic [LINK_W-1:0] head_in;
   logic [8:0]        free_in;

   logic [CMP_W-1:0]  max_ext;
   logic [CMP_W-1:0]  bc_ext;
   logic [CMP_W-1:0]  size;
   logic [CMP_W-1:0]  wr_ext;
   logic [CMP_W-1:0]  new_size;
   logic [CMP_W-1:0]  head_ext;
   logic [CMP_W-1:0]  idx_ext;
   logic              alloc_ok;
   logic              free_ok;
   logic              clearing;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [LINK_W-1:0] wr_data;

   always_comb begin
      max_ext  = CMP_W'(MAX_BLOCKS);
      bc_ext   = CMP_W'(block_count_ff);
      size     = (bc_ext > max_ext) ? max_ext : bc_ext;
      wr_ext   = CMP_W'(csr_wr_data);
      new_size = (wr_ext > max_ext) ? max_ext : wr_ext;
      head_ext = CMP_W'(head_ff);
      idx_ext  = CMP_W'(idx_ff);

      alloc_ok = (op_ff == OP_ALLOC) && (free_ff != 9'd0) && (head_ext < size);
      free_ok  = (op_ff == OP_FREE) && (idx_ext < size);

      head_in = head_ff;
      free_in = free_ff;
      if (alloc_ok) begin
         head_in = rd_data_ff;
         free_in = free_ff - 9'd1;
      end else if (free_ok) begin
         head_in = idx_ext[LINK_W-1:0];
         free_in = free_ff + 9'd1;
      end

      rsp_in.block_index = alloc_ok ? head_ext[7:0] : 8'd0;
      rsp_in.free_count  = free_in;
      if (op_ff == OP_ALLOC) begin
         rsp_in.status = alloc_ok ? STATUS_OK : STATUS_FULL;
      end else begin
         rsp_in.status = free_ok ? STATUS_OK : STATUS_BAD_INDEX;
      end

      clearing = cmd.clear_step && (clr_cnt_ff != CNT_W'(MAX_BLOCKS));
      wr_en    = clearing || (cmd.commit && free_ok);
      wr_addr  = clearing ? clr_cnt_ff[ADDR_W-1:0] : idx_ext[ADDR_W-1:0];
      wr_data  = clearing ? LINK_W'(clr_cnt_ff + CNT_W'(1)) : head_ff;

      rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);

      sts.clear_done = (clr_cnt_ff == CNT_W'(MAX_BLOCKS));
      sts.rsp_ready  = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      if (cmd.accept) begin
         rd_data_ff <= link_mem[head_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_data.cmd;
         idx_ff <= req_data.free_index;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= BLOCK_COUNT_RESET;
         head_ff        <= '0;
         free_ff        <= 9'(RST_SIZE);
         clr_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            block_count_ff <= csr_wr_data;
            head_ff        <= '0;
            free_ff        <= new_size[8:0];
            clr_cnt_ff     <= '0;
         end else begin
            if (clearing) begin
               clr_cnt_ff <= clr_cnt_ff + CNT_W'(1);
            end
            if (cmd.commit) begin
               head_ff <= head_in;
               free_ff <= free_in;
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hw/rtl/fixed_block_free_list_allocator_unit.sv]
// Top level of the fixed block free list allocator.
// Depends on fbla_pkg, fbla_ctrl and fbla_datapath.
//
//   Channel   Ports                           Direction   Beat
//   request   req_valid req_stall req_data    in          req_type
//   response  rsp_valid rsp_stall rsp_data    out         rsp_type
//   config    csr_wr_en csr_wr_data           in          block count
//
// Each request is handled in two steps: the link of the head block is read from
// the link memory, then the head, the counter and the result register are updated.
// After reset and after each block count write, the link memory is rebuilt one
// entry per cycle, with req_stall held high.
// A result waits in the output register while rsp_stall is high; the next
// request is accepted meanwhile but does not finish until that result is taken.
`timescale 1ns / 1ps

module fixed_block_free_list_allocator_unit import fbla_pkg::*; #(
   parameter int MAX_BLOCKS = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [8:0] csr_wr_data
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   fbla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .csr_wr_en (csr_wr_en),
      .sts       (sts),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   fbla_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted in back-to-back cycles");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !csr_wr_en) |=> ##1 rsp_valid)
      else $error("no response two cycles after an accepted request");

   assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> req_stall)
      else $error("request taken while the link list is being rebuilt");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_OK) |-> (rsp_data.block_index == 8'd0))
      else $error("failed operation reports a block index");

endmodule
